// ===== design/slad_pkg.sv =====
// ============================================================================
// slad_pkg
// Shared types and constants for the sequential list with append and delete.
// ============================================================================
package slad_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int ENTRY_WIDTH_DEF = 32;

  localparam int OP_W   = 2;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SHIFT,
    S_DONE
  } slad_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic append_wr;
    logic read_issue;
    logic read_take;
    logic del_init;
    logic shift;
    logic del_last;
  } slad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_append;
    logic is_delete;
    logic is_read;
    logic full;
    logic illegal;
    logic shift_more;
    logic wpend;
  } slad_stat_t;

endpackage

// ===== design/slad_ctrl.sv =====
// ============================================================================
// slad_ctrl
// Controller state machine that sequences one list operation at a time.
// ============================================================================
module slad_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  slad_pkg::slad_stat_t  stat,
  output slad_pkg::slad_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  slad_pkg::slad_state_t state;
  slad_pkg::slad_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slad_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slad_pkg::S_IDLE: begin
        if (start) begin
          state_next = slad_pkg::S_DECODE;
        end
      end
      slad_pkg::S_DECODE: begin
        priority if (stat.is_read && !stat.illegal) begin
          state_next = slad_pkg::S_READ_WAIT;
        end else if (stat.is_delete && !stat.illegal) begin
          state_next = slad_pkg::S_SHIFT;
        end else begin
          state_next = slad_pkg::S_DONE;
        end
      end
      slad_pkg::S_READ_WAIT: begin
        state_next = slad_pkg::S_DONE;
      end
      slad_pkg::S_SHIFT: begin
        if (!stat.shift_more && !stat.wpend) begin
          state_next = slad_pkg::S_DONE;
        end
      end
      slad_pkg::S_DONE: begin
        state_next = slad_pkg::S_IDLE;
      end
      default: begin
        state_next = slad_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      slad_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      slad_pkg::S_DECODE: begin
        cmd.decode     = 1'b1;
        cmd.append_wr  = stat.is_append && !stat.full;
        cmd.read_issue = stat.is_read && !stat.illegal;
        cmd.del_init   = stat.is_delete && !stat.illegal;
      end
      slad_pkg::S_READ_WAIT: begin
        cmd.read_take = 1'b1;
      end
      slad_pkg::S_SHIFT: begin
        cmd.shift    = 1'b1;
        cmd.del_last = !stat.shift_more && !stat.wpend;
      end
      slad_pkg::S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/slad_dp.sv =====
// ============================================================================
// slad_dp
// Datapath: operand registers, entry memory, length count and result registers.
// ============================================================================
module slad_dp #(
  parameter int CAPACITY    = slad_pkg::CAPACITY_DEF,
  parameter int ENTRY_WIDTH = slad_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  slad_pkg::slad_cmd_t           cmd,
  output slad_pkg::slad_stat_t          stat,
  input  logic [slad_pkg::OP_W-1:0]     operation,
  input  logic [slad_pkg::POS_W-1:0]    position,
  input  logic [slad_pkg::DATA_W-1:0]   entry_data,
  output logic [slad_pkg::STAT_W-1:0]   status,
  output logic [slad_pkg::DATA_W-1:0]   read_data,
  output logic [slad_pkg::LEN_W-1:0]    list_length
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > slad_pkg::POS_W) ? CW : slad_pkg::POS_W;

  logic [ENTRY_WIDTH-1:0]         mem [CAPACITY];

  logic [slad_pkg::OP_W-1:0]      op_q;
  logic [slad_pkg::POS_W-1:0]     pos_q;
  logic [ENTRY_WIDTH-1:0]         data_q;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  sidx;
  logic [AW-1:0]                  waddr;
  logic                           wpend;
  logic [ENTRY_WIDTH-1:0]         rd_q;
  logic [slad_pkg::STAT_W-1:0]    res_status;
  logic [slad_pkg::DATA_W-1:0]    res_data;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [ENTRY_WIDTH-1:0]         mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [AW-1:0]                  pos_idx;
  logic [slad_pkg::STAT_W-1:0]    status_code;

  // Operation decode and range checks.
  always_comb begin
    stat.is_append  = (op_q == slad_pkg::OP_APPEND);
    stat.is_delete  = (op_q == slad_pkg::OP_DELETE);
    stat.is_read    = (op_q == slad_pkg::OP_READ);
    stat.full       = (count >= CW'(CAPACITY));
    stat.illegal    = (pos_q == '0) || (CMPW'(pos_q) > CMPW'(count));
    stat.shift_more = (sidx < count);
    stat.wpend      = wpend;
  end

  assign pos_idx = AW'(pos_q - slad_pkg::POS_W'(1));

  always_comb begin
    priority if (stat.is_append && stat.full) begin
      status_code = slad_pkg::STAT_FULL;
    end else if ((stat.is_delete || stat.is_read) && stat.illegal) begin
      status_code = slad_pkg::STAT_ILLEGAL;
    end else begin
      status_code = slad_pkg::STAT_OK;
    end
  end

  // One write port and one read port; a shift reads one place ahead of its write.
  assign mem_we    = cmd.append_wr || (cmd.shift && wpend);
  assign mem_waddr = cmd.append_wr ? count[AW-1:0] : waddr;
  assign mem_wdata = cmd.append_wr ? data_q : rd_q;
  assign mem_re    = cmd.read_issue || (cmd.shift && stat.shift_more);
  assign mem_raddr = cmd.read_issue ? pos_idx : sidx[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wpend <= 1'b0;
    end else begin
      if (cmd.append_wr) begin
        count <= count + CW'(1);
      end else if (cmd.del_last) begin
        count <= count - CW'(1);
      end
      if (cmd.del_init) begin
        wpend <= 1'b0;
      end else if (cmd.shift) begin
        wpend <= stat.shift_more;
      end
    end
  end

  // Operands, shift pointers and results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= operation;
      pos_q    <= position;
      data_q   <= ENTRY_WIDTH'(entry_data);
      res_data <= '0;
    end
    if (cmd.decode) begin
      res_status <= status_code;
    end
    if (cmd.read_take) begin
      res_data <= slad_pkg::DATA_W'(rd_q);
    end
    if (cmd.del_init) begin
      sidx <= CW'(pos_q);
    end else if (cmd.shift && stat.shift_more) begin
      sidx  <= sidx + CW'(1);
      waddr <= AW'(sidx - CW'(1));
    end
  end

  assign status      = res_status;
  assign read_data   = res_data;
  assign list_length = slad_pkg::LEN_W'(count);

endmodule

// ===== design/sequential_list_append_delete.sv =====
// ============================================================================
// sequential_list_append_delete
// Fixed-capacity list of entry words with append, delete-with-shift and read.
// ============================================================================
//
//   Channel   Handshake          Payload
//   --------  -----------------  -----------------------------------------
//   command   start / busy       operation, position, entry_data
//   result    done (one cycle)   status, read_data, list_length
//
// A command transaction is taken at an edge with start high and busy low. Its
// result follows the decode state, a read's the read-wait state after it; a
// legal delete at p in a list of n moves n - p entries one per cycle in the
// shift state before its result. busy falls in the cycle after the result.
// Reset empties the list at once; the entry memory itself is not cleared.
// The result transaction shows for exactly one cycle and cannot be stalled.
module sequential_list_append_delete #(
  parameter int CAPACITY    = slad_pkg::CAPACITY_DEF,
  parameter int ENTRY_WIDTH = slad_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [slad_pkg::OP_W-1:0]     operation,
  input  logic [slad_pkg::POS_W-1:0]    position,
  input  logic [slad_pkg::DATA_W-1:0]   entry_data,
  output logic                          done,
  output logic [slad_pkg::STAT_W-1:0]   status,
  output logic [slad_pkg::DATA_W-1:0]   read_data,
  output logic [slad_pkg::LEN_W-1:0]    list_length
);

  // The controller and datapath talk only through these two bundles.
  slad_pkg::slad_cmd_t  cmd;
  slad_pkg::slad_stat_t stat;

  // The controller steps through decode, an optional read wait or shift
  // phase, and a single result cycle.
  slad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the entry memory, the length count and the result
  // registers that drive the result ports.
  slad_dp #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .position    (position),
    .entry_data  (entry_data),
    .status      (status),
    .read_data   (read_data),
    .list_length (list_length)
  );

endmodule

// ===== design/slad_chk.sv =====
// ============================================================================
// slad_chk
// Port-level checks for the sequential list, attached to the top level.
// ============================================================================
module slad_chk #(
  parameter int CAPACITY = slad_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [slad_pkg::STAT_W-1:0]   status,
  input logic [slad_pkg::LEN_W-1:0]    list_length
);

  // An accepted command holds the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted command");

  // A result never appears while the block claims to be idle.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // The block only goes idle right after it delivered a result.
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  // A full report only comes with a list at capacity.
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    done && status == slad_pkg::STAT_FULL |-> list_length == slad_pkg::LEN_W'(CAPACITY))
    else $error("full status with a list below capacity");

  // A result carries a defined status code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == slad_pkg::STAT_OK || status == slad_pkg::STAT_FULL ||
             status == slad_pkg::STAT_ILLEGAL)
    else $error("undefined status code");

endmodule

bind sequential_list_append_delete slad_chk #(
  .CAPACITY (CAPACITY)
) u_slad_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .list_length (list_length)
);
